FILE: sv/lca_pkg.sv
// Shared types and codes for the life engine.
// Holds op codes, the controller state type and the control/status structs.
// Depends on nothing.
package lca_pkg;

    localparam logic [1:0] OP_TOGGLE = 2'd0;
    localparam logic [1:0] OP_STEP   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP_RD,
        ST_STEP_SH,
        ST_STEP_WR,
        ST_ITEM_RD,
        ST_ITEM_FIN
    } state_t;

    typedef struct packed {
        logic capture;
        logic win_clr;
        logic cnt_clr;
        logic cnt_inc;
        logic clr_wr;
        logic step_rd;
        logic step_sh;
        logic step_wr;
        logic item_rd;
        logic item_fin;
    } cmd_t;

    typedef struct packed {
        logic [1:0] in_op;
        logic       cnt_zero;
        logic       cnt_end;
        logic       clr_last;
        logic       out_free;
    } status_t;

endpackage

FILE: sv/life_cellular_automaton_engine_unit.sv
// Top level of the life engine: Conway B3/S23 on a bounded, non-wrapping grid.
// Joins the controller (lca_ctrl) and the datapath (lca_datapath); uses lca_pkg.
//
// Input channel (in_valid/in_ready) carries op, x and y; output channel
// (out_valid/out_ready) carries alive, the state of cell x,y after the op.
// Op 0 toggles a cell, op 1 advances one generation, op 2 (and op 3) reads.
// Cells are stored one row per memory word. A toggle or read reads the row,
// then registers its result; input is ready again once the block is back in
// idle. A generation sweeps the rows through a three-row window, with a read,
// a shift and a write step per row; the single-port row memory and the row
// sequencer set how long a step takes.
// One item is worked on at a time; in_ready is high only when the block is
// idle. A finished result sits in the output register, and the block may
// accept the next item while it waits. If the receiver stalls, the next
// result is held back until the register is free.
// After reset a clearing pass writes every row dead, during which no item
// is accepted.
module life_cellular_automaton_engine_unit #(
    parameter int GRID_WIDTH  = 256,
    parameter int GRID_HEIGHT = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] x,
    input  logic [7:0] y,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       alive
);

    lca_pkg::cmd_t    cmd;
    lca_pkg::status_t st;

    lca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    lca_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .op        (op),
        .x         (x),
        .y         (y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .alive     (alive)
    );

    a_clear_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_wr |-> !in_ready)
        else $error("Item could be accepted during the clearing pass.");

    a_one_item_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("Input stayed ready after an item was accepted.");

    a_result_not_lost : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.item_fin |-> (!out_valid || out_ready))
        else $error("Result written over a pending result.");

    a_toggle_writes_only_toggle : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_wr || cmd.clr_wr) |-> !cmd.item_fin)
        else $error("Two writers on the cell memory at once.");

endmodule

FILE: sv/lca_ctrl.sv
// Controller state machine for the life engine.
// Sequences the clearing pass, the generation sweep and single-cell items.
// Depends on lca_pkg.
module lca_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lca_pkg::status_t st,
    output lca_pkg::cmd_t    cmd
);

    lca_pkg::state_t state_reg;
    lca_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lca_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lca_pkg::ST_CLEAR:
            begin
                if (st.clr_last)
                begin
                    state_next = lca_pkg::ST_IDLE;
                end
            end
            lca_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (st.in_op == lca_pkg::OP_STEP)
                    begin
                        state_next = lca_pkg::ST_STEP_RD;
                    end
                    else
                    begin
                        state_next = lca_pkg::ST_ITEM_RD;
                    end
                end
            end
            lca_pkg::ST_STEP_RD:
            begin
                state_next = lca_pkg::ST_STEP_SH;
            end
            lca_pkg::ST_STEP_SH:
            begin
                state_next = lca_pkg::ST_STEP_WR;
            end
            lca_pkg::ST_STEP_WR:
            begin
                if (st.cnt_end)
                begin
                    state_next = lca_pkg::ST_ITEM_RD;
                end
                else
                begin
                    state_next = lca_pkg::ST_STEP_RD;
                end
            end
            lca_pkg::ST_ITEM_RD:
            begin
                state_next = lca_pkg::ST_ITEM_FIN;
            end
            lca_pkg::ST_ITEM_FIN:
            begin
                if (st.out_free)
                begin
                    state_next = lca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lca_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            lca_pkg::ST_CLEAR:
            begin
                cmd.clr_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            lca_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                cmd.win_clr = in_valid;
                cmd.cnt_clr = in_valid;
            end
            lca_pkg::ST_STEP_RD:
            begin
                cmd.step_rd = 1'b1;
            end
            lca_pkg::ST_STEP_SH:
            begin
                cmd.step_sh = 1'b1;
            end
            lca_pkg::ST_STEP_WR:
            begin
                cmd.step_wr = !st.cnt_zero;
                cmd.cnt_inc = 1'b1;
            end
            lca_pkg::ST_ITEM_RD:
            begin
                cmd.item_rd = 1'b1;
            end
            lca_pkg::ST_ITEM_FIN:
            begin
                cmd.item_fin = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: sv/lca_datapath.sv
// Datapath for the life engine: row-wide cell memory, three-row window,
// per-column rule logic, row counter and result register. Depends on lca_pkg.
module lca_datapath #(
    parameter int GRID_WIDTH  = 256,
    parameter int GRID_HEIGHT = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  lca_pkg::cmd_t    cmd,
    output lca_pkg::status_t st,
    input  logic [1:0]       op,
    input  logic [7:0]       x,
    input  logic [7:0]       y,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             alive
);

    localparam int RW  = $clog2(GRID_HEIGHT);
    localparam int CW  = $clog2(GRID_HEIGHT + 1);
    localparam int CLW = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;

    logic [GRID_WIDTH-1:0] mem [GRID_HEIGHT];

    logic [1:0]            op_reg;
    logic [7:0]            x_reg;
    logic [7:0]            y_reg;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_dec;
    logic [GRID_WIDTH-1:0] rdata_reg;
    logic [GRID_WIDTH-1:0] up_reg;
    logic [GRID_WIDTH-1:0] mid_reg;
    logic [GRID_WIDTH-1:0] dn_reg;
    logic                  out_valid_reg;
    logic                  alive_reg;

    logic [31:0]           x_ext;
    logic [31:0]           y_ext;
    logic                  on_grid;
    logic [RW-1:0]         item_addr;
    logic [CLW-1:0]        col_idx;
    logic [GRID_WIDTH-1:0] col_mask;
    logic [GRID_WIDTH-1:0] item_row;
    logic [GRID_WIDTH-1:0] life_row;
    logic [GRID_WIDTH+1:0] up_pad;
    logic [GRID_WIDTH+1:0] mid_pad;
    logic [GRID_WIDTH+1:0] dn_pad;
    logic                  item_wr;
    logic                  wr_en;
    logic [RW-1:0]         wr_addr;
    logic [GRID_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [RW-1:0]         rd_addr;

    assign x_ext     = 32'(x_reg);
    assign y_ext     = 32'(y_reg);
    assign on_grid   = (x_ext < 32'(GRID_WIDTH)) && (y_ext < 32'(GRID_HEIGHT));
    assign item_addr = y_ext[RW-1:0];
    assign col_idx   = x_ext[CLW-1:0];
    assign col_mask  = {{(GRID_WIDTH-1){1'b0}}, 1'b1} << col_idx;
    assign cnt_dec   = cnt_reg - 1'b1;

    assign item_row  = (op_reg == lca_pkg::OP_TOGGLE && on_grid) ?
                       (rdata_reg ^ col_mask) : rdata_reg;
    assign item_wr   = cmd.item_fin && on_grid && (op_reg == lca_pkg::OP_TOGGLE);

    assign up_pad  = {1'b0, up_reg, 1'b0};
    assign mid_pad = {1'b0, mid_reg, 1'b0};
    assign dn_pad  = {1'b0, dn_reg, 1'b0};

    for (genvar c = 0; c < GRID_WIDTH; c++)
    begin : g_col
        logic [3:0] n;
        always_comb
        begin
            n = 4'(up_pad[c]) + 4'(up_pad[c+1]) + 4'(up_pad[c+2])
              + 4'(mid_pad[c]) + 4'(mid_pad[c+2])
              + 4'(dn_pad[c]) + 4'(dn_pad[c+1]) + 4'(dn_pad[c+2]);
            life_row[c] = (n == 4'd3) || (mid_reg[c] && n == 4'd2);
        end
    end

    always_comb
    begin
        wr_en   = cmd.clr_wr || cmd.step_wr || item_wr;
        wr_addr = item_addr;
        wr_data = item_row;
        if (cmd.clr_wr)
        begin
            wr_addr = cnt_reg[RW-1:0];
            wr_data = '0;
        end
        else if (cmd.step_wr)
        begin
            wr_addr = cnt_dec[RW-1:0];
            wr_data = life_row;
        end
    end

    assign rd_en   = cmd.item_rd || (cmd.step_rd && !st.cnt_end);
    assign rd_addr = cmd.item_rd ? item_addr : cnt_reg[RW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= op;
            x_reg  <= x;
            y_reg  <= y;
        end
        if (cmd.win_clr)
        begin
            up_reg  <= '0;
            mid_reg <= '0;
            dn_reg  <= '0;
        end
        else if (cmd.step_sh)
        begin
            up_reg  <= mid_reg;
            mid_reg <= dn_reg;
            dn_reg  <= st.cnt_end ? '0 : rdata_reg;
        end
        if (cmd.item_fin)
        begin
            alive_reg <= on_grid && item_row[col_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.item_fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        st.in_op    = op;
        st.cnt_zero = (cnt_reg == '0);
        st.cnt_end  = (cnt_reg == CW'(GRID_HEIGHT));
        st.clr_last = (cnt_reg == CW'(GRID_HEIGHT - 1));
        st.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign alive     = alive_reg;

endmodule
